// ===== hdl/spi_mbe_pkg.sv =====
// Package for the SPI master bit engine: command codes, register indexes,
// and the item and result structs shared by the core, output stage and top.
// No dependencies.
`default_nettype none

package spi_mbe_pkg;

  // Command carried with each input item
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_OPEN  = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_SPI_MODE       = 3'd0;
  localparam logic [2:0] CFG_WORD_BITS      = 3'd1;
  localparam logic [2:0] CFG_LSB_FIRST      = 3'd2;
  localparam logic [2:0] CFG_CS_ACTIVE_HIGH = 3'd3;
  localparam logic [2:0] CFG_UNIT_TICKS     = 3'd4;

  // Width of the serial data words
  localparam int unsigned DATA_W = 16;

  // One tick of the serial timeline
  typedef struct packed {
    cmd_t              command;
    logic [DATA_W-1:0] tx_word;
    logic              miso_level;
  } item_t;

  // Pin levels and word status after one tick
  typedef struct packed {
    logic              sclk_level;
    logic              mosi_level;
    logic              cs_level;
    logic [DATA_W-1:0] rx_word;
    logic              word_done;
    logic              busy_res;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/spi_mbe_core.sv =====
// SPI master bit engine core: configuration registers, transfer state and
// the single-pass next-state logic for one tick. Depends on spi_mbe_pkg.
`default_nettype none

module spi_mbe_core import spi_mbe_pkg::*; #(
  parameter int unsigned MAX_WORD_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          fire,
  input  wire item_t         item,
  output result_t            result
);

  localparam int unsigned CW = $clog2(MAX_WORD_BITS + 1);

  // Configuration
  logic [1:0]  spi_mode;
  logic [4:0]  word_bits;
  logic        lsb_first;
  logic        cs_active_high;
  logic [15:0] unit_ticks;

  // Transfer state
  logic [DATA_W-1:0] tx_shift, tx_shift_next;
  logic [DATA_W-1:0] rx_shift, rx_shift_next;
  logic [CW-1:0]     bit_count, bit_count_next;
  logic              in_second_phase, in_second_phase_next;
  logic [16:0]       phase_timer, phase_timer_next;
  logic              active, active_next;
  logic              selected, selected_next;
  logic              clk_reg, clk_reg_next;
  logic              mosi_reg, mosi_reg_next;

  // Effective settings
  logic [5:0]    wb6, eff6;
  logic [CW-1:0] eff_bits;
  logic [15:0]   eff_unit;
  logic          lead;

  assign wb6  = {1'b0, word_bits};
  assign eff6 = (wb6 == 6'd0) ? 6'd1 :
                (wb6 > 6'(MAX_WORD_BITS)) ? 6'(MAX_WORD_BITS) : wb6;
  assign eff_bits = CW'(eff6);
  assign eff_unit = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;
  assign lead     = spi_mode[1] ^ spi_mode[0];

  // Bit-begin inputs and outputs
  logic [CW-1:0]     bb_count;
  logic [DATA_W-1:0] bb_tx, bb_rx, bb_rx_out;
  logic [CW-1:0]     pos;
  logic [5:0]        pos6;
  logic              pos_ok;
  logic              bb_mosi;
  logic [CW-1:0]     count_inc;
  logic              done;
  logic [DATA_W-1:0] rx_out;

  assign pos    = lsb_first ? bb_count : (eff_bits - CW'(1) - bb_count);
  assign pos6   = 6'(pos);
  assign pos_ok = (pos6 < 6'(DATA_W));
  assign bb_mosi   = pos_ok & bb_tx[pos6[3:0]];
  assign bb_rx_out = (pos_ok && item.miso_level) ?
                     (bb_rx | (DATA_W'(1) << pos6[3:0])) : bb_rx;
  assign count_inc = bit_count + CW'(1);

  // Next state for one tick
  always_comb begin
    tx_shift_next        = tx_shift;
    rx_shift_next        = rx_shift;
    bit_count_next       = bit_count;
    in_second_phase_next = in_second_phase;
    phase_timer_next     = phase_timer;
    active_next          = active;
    selected_next        = selected;
    clk_reg_next         = clk_reg;
    mosi_reg_next        = mosi_reg;
    bb_count             = count_inc;
    bb_tx                = tx_shift;
    bb_rx                = rx_shift;
    done                 = 1'b0;
    rx_out               = '0;

    // Chip select
    if (item.command == CMD_OPEN) begin
      selected_next = 1'b1;
      if (!active) clk_reg_next = spi_mode[1];
    end else if (item.command == CMD_CLOSE) begin
      selected_next = 1'b0;
    end

    if (active) begin
      if (phase_timer != 17'd0) begin
        phase_timer_next = phase_timer - 17'd1;
      end else if (!in_second_phase) begin
        in_second_phase_next = 1'b1;
        clk_reg_next         = ~lead;
        phase_timer_next     = {eff_unit, 1'b0} - 17'd1;
      end else if (count_inc >= eff_bits) begin
        // last bit finished
        done                 = 1'b1;
        rx_out               = rx_shift;
        active_next          = 1'b0;
        in_second_phase_next = 1'b0;
        phase_timer_next     = '0;
        bit_count_next       = '0;
        if (spi_mode == 2'd0) clk_reg_next = 1'b0;
      end else begin
        // next bit
        bit_count_next       = count_inc;
        clk_reg_next         = lead;
        mosi_reg_next        = bb_mosi;
        rx_shift_next        = bb_rx_out;
        in_second_phase_next = 1'b0;
        phase_timer_next     = {1'b0, eff_unit - 16'd1};
      end
    end else if (item.command == CMD_START) begin
      bb_count             = '0;
      bb_tx                = item.tx_word;
      bb_rx                = '0;
      tx_shift_next        = item.tx_word;
      bit_count_next       = '0;
      active_next          = 1'b1;
      clk_reg_next         = lead;
      mosi_reg_next        = bb_mosi;
      rx_shift_next        = bb_rx_out;
      in_second_phase_next = 1'b0;
      phase_timer_next     = {1'b0, eff_unit - 16'd1};
    end

    result.sclk_level = clk_reg_next;
    result.mosi_level = mosi_reg_next;
    result.cs_level   = selected_next ? cs_active_high : ~cs_active_high;
    result.rx_word    = rx_out;
    result.word_done  = done;
    result.busy_res   = active_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spi_mode       <= 2'd0;
      word_bits      <= 5'd8;
      lsb_first      <= 1'b0;
      cs_active_high <= 1'b0;
      unit_ticks     <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPI_MODE:       spi_mode       <= cfg_data[1:0];
        CFG_WORD_BITS:      word_bits      <= cfg_data[4:0];
        CFG_LSB_FIRST:      lsb_first      <= cfg_data[0];
        CFG_CS_ACTIVE_HIGH: cs_active_high <= cfg_data[0];
        CFG_UNIT_TICKS:     unit_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Transfer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift        <= '0;
      rx_shift        <= '0;
      bit_count       <= '0;
      in_second_phase <= 1'b0;
      phase_timer     <= '0;
      active          <= 1'b0;
      selected        <= 1'b0;
      clk_reg         <= 1'b0;
      mosi_reg        <= 1'b0;
    end else if (fire) begin
      tx_shift        <= tx_shift_next;
      rx_shift        <= rx_shift_next;
      bit_count       <= bit_count_next;
      in_second_phase <= in_second_phase_next;
      phase_timer     <= phase_timer_next;
      active          <= active_next;
      selected        <= selected_next;
      clk_reg         <= clk_reg_next;
      mosi_reg        <= mosi_reg_next;
    end
  end

  // Idle engine holds no leftover bit position or timer
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !active |-> (bit_count == '0 && phase_timer == '0 && !in_second_phase))
    else $error("idle engine has stale transfer state");

  // Second phase only exists inside a transfer
  a_phase_in_xfer: assert property (@(posedge clk) disable iff (rst)
    in_second_phase |-> active)
    else $error("second phase flagged while idle");

  // A transfer ends only through a completed word
  a_end_by_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(active) && !$past(rst)) |-> $past(fire && done))
    else $error("transfer dropped without word completion");

  // Word completion reports not busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && done) |-> !active_next)
    else $error("word done while still busy");

endmodule

`default_nettype wire

// ===== hdl/spi_mbe_oreg.sv =====
// Result register for the SPI master bit engine: holds one tick's result
// until the downstream side takes it. Depends on spi_mbe_pkg.
`default_nettype none

module spi_mbe_oreg import spi_mbe_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t din,
  input  wire logic    take,
  output logic         valid,
  output result_t      dout
);

  // Valid flag: set on load, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) dout <= din;
  end

endmodule

`default_nettype wire

// ===== hdl/spi_master_bit_engine_unit.sv =====
// Top level of the SPI master bit engine: input register, handshakes and
// the core and result stages. Depends on spi_mbe_pkg, spi_mbe_core and
// spi_mbe_oreg.
//
//  channel   dir  transfer when          payload
//  s_*       in   s_tvalid & s_tready    tuser command; tdata tx_word, miso_level
//  m_*       out  m_tvalid & m_tready    tuser word_done; tdata pins, rx_word, busy
//  cfg_*     in   cfg_we                 cfg_index register, cfg_data value
//
// One tick per cycle while the output is not stalled: a transfer lands in the
// input register, is processed through the core's next-state logic and lands in
// the result register, which loads together with the core's state registers.
// Reset (rst, synchronous) clears the state and restores the default configuration.
// A stalled output holds its result; input is still taken while the
// result register drains in the same cycle.
`default_nettype none

module spi_master_bit_engine_unit import spi_mbe_pkg::*; #(
  parameter int unsigned MAX_WORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [15:0] tx_word, [16] miso_level, zero pad
  input  wire logic [1:0]  s_tuser,   // [1:0] command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [0] sclk, [1] mosi, [2] cs, [18:3] rx_word,
                                      // [19] busy_res, zero pad
  output logic             m_tuser,   // [0] word_done
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic    in_valid;
  item_t   in_item;
  logic    advance;
  result_t core_res;
  result_t out_res;

  // Input register moves into the core when the result stage has room
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command    <= cmd_t'(s_tuser);
      in_item.tx_word    <= s_tdata[15:0];
      in_item.miso_level <= s_tdata[16];
    end
  end

  spi_mbe_core #(
    .MAX_WORD_BITS(MAX_WORD_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (in_item),
    .result    (core_res)
  );

  spi_mbe_oreg u_oreg (
    .clk   (clk),
    .rst   (rst),
    .load  (advance),
    .din   (core_res),
    .take  (m_tready),
    .valid (m_tvalid),
    .dout  (out_res)
  );

  // Output packing
  assign m_tdata = {4'd0, out_res.busy_res, out_res.rx_word, out_res.cs_level,
                    out_res.mosi_level, out_res.sclk_level};
  assign m_tuser = out_res.word_done;

endmodule

`default_nettype wire

// ===== verif/spi_master_bit_engine_unit_tb.sv =====
// Testbench for spi_master_bit_engine_unit: drives serial ticks as stream transfers,
// predicts pin levels and received words per tick, and checks every result.
// Depends on spi_mbe_pkg and the spi_master_bit_engine_unit RTL.
module spi_master_bit_engine_unit_tb import spi_mbe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_TICKS = 1450;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [15:0] tx_word, [16] miso_level, zero pad
  logic [1:0]  s_tuser = '0;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [0] sclk, [1] mosi, [2] cs, [18:3] rx_word, [19] busy
  logic        m_tuser;        // [0] word_done
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  spi_master_bit_engine_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectation stores
  item_t   tick_queue[$];
  result_t expected_pins[$];
  item_t   cur_item;
  int      src_wait = 0;
  int      sink_wait = 0;
  int      quiet = 0;
  bit      src_idle_on = 1'b1;
  bit      sink_idle_on = 1'b1;
  int      errors = 0;
  int      ticks_sent = 0;
  int      words_done = 0;
  int      settings = 0;
  int      queued = 0;

  // Predictor configuration (reset values)
  logic [1:0]  mode_r = 2'd0;
  logic [4:0]  bits_r = 5'd8;
  logic        lsbf_r = 1'b0;
  logic        cshi_r = 1'b0;
  logic [15:0] unit_r = 16'd1;

  // Predictor serial state
  logic [31:0] tx_sh = '0;
  logic [31:0] rx_sh = '0;
  logic [4:0]  bit_idx = '0;
  logic        in_ph2 = 1'b0;
  logic [16:0] ph_timer = '0;
  logic        xfer_on = 1'b0;
  logic        cs_sel = 1'b0;
  logic        sclk_q = 1'b0;
  logic        mosi_q = 1'b0;

  function automatic int unsigned bits_eff();
    if (bits_r == 5'd0) return 1;
    if (bits_r > 5'd16) return 16;
    return 32'(bits_r);
  endfunction

  function automatic int unsigned unit_eff();
    return (unit_r == 16'd0) ? 1 : 32'(unit_r);
  endfunction

  // Clock level during the first phase of a bit: low for modes 0 and 3
  function automatic logic lead_level();
    return mode_r[1] ^ mode_r[0];
  endfunction

  // First phase of bit bit_idx: drive lead clock and MOSI, sample MISO
  function automatic void launch_bit(input logic miso);
    int unsigned pos;
    pos = lsbf_r ? 32'(bit_idx) : (bits_eff() - 1 - 32'(bit_idx));
    pos = pos & 31;
    sclk_q = lead_level();
    mosi_q = tx_sh[pos[4:0]];
    if (miso) rx_sh[pos[4:0]] = 1'b1;
    in_ph2 = 1'b0;
    ph_timer = 17'(unit_eff() - 1);
  endfunction

  // Advance the serial timeline by one tick and return the pin levels
  function automatic result_t spi_tick(input item_t it);
    result_t     r;
    logic        done;
    logic [15:0] rxo;
    done = 1'b0;
    rxo = '0;
    if (it.command == CMD_OPEN) begin
      cs_sel = 1'b1;
      if (!xfer_on) sclk_q = mode_r[1];
    end else if (it.command == CMD_CLOSE) begin
      cs_sel = 1'b0;
    end
    if (xfer_on) begin
      if (ph_timer != 17'd0) begin
        ph_timer = ph_timer - 17'd1;
      end else if (!in_ph2) begin
        in_ph2 = 1'b1;
        sclk_q = ~lead_level();
        ph_timer = 17'(2 * unit_eff() - 1);
      end else begin
        bit_idx = bit_idx + 5'd1;
        if (32'(bit_idx) >= bits_eff()) begin
          done = 1'b1;
          rxo = rx_sh[15:0];
          xfer_on = 1'b0;
          in_ph2 = 1'b0;
          ph_timer = '0;
          bit_idx = '0;
          if (mode_r == 2'd0) sclk_q = 1'b0;
        end else begin
          launch_bit(it.miso_level);
        end
      end
    end else if (it.command == CMD_START) begin
      tx_sh = {16'h0, it.tx_word};
      rx_sh = '0;
      bit_idx = '0;
      xfer_on = 1'b1;
      launch_bit(it.miso_level);
    end
    r.sclk_level = sclk_q;
    r.mosi_level = mosi_q;
    r.cs_level = cs_sel ? cshi_r : ~cshi_r;
    r.rx_word = rxo;
    r.word_done = done;
    r.busy_res = xfer_on;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Source side: feed queued ticks, predict each one on its transfer
  always @(posedge clk) begin : src_drv
    item_t nx;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_pins.push_back(spi_tick(cur_item));
        ticks_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_wait != 0) begin
          src_wait <= src_wait - 1;
          s_tvalid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          nx = tick_queue.pop_front();
          cur_item <= nx;
          s_tvalid <= 1'b1;
          s_tdata <= {7'd0, nx.miso_level, nx.tx_word};
          s_tuser <= nx.command;
          src_wait <= src_idle_on ? $urandom_range(0, 12) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: random stalls, compare each result with the oldest prediction
  always @(posedge clk) begin : sink_mon
    result_t want;
    int      w;
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      if (expected_pins.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual tdata %h tuser %b",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = expected_pins.pop_front();
        check_field("sclk_level", 16'(want.sclk_level), 16'(m_tdata[0]));
        check_field("mosi_level", 16'(want.mosi_level), 16'(m_tdata[1]));
        check_field("cs_level", 16'(want.cs_level), 16'(m_tdata[2]));
        check_field("rx_word", want.rx_word, m_tdata[18:3]);
        check_field("busy_res", 16'(want.busy_res), 16'(m_tdata[19]));
        check_field("word_done", 16'(want.word_done), 16'(m_tuser));
        if (want.word_done) words_done++;
      end
      w = sink_idle_on ? $urandom_range(0, 12) : 0;
      sink_wait <= w;
      m_tready <= (w == 0);
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      m_tready <= (sink_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_item(input cmd_t c, input logic [15:0] t, input logic m);
    item_t it;
    it.command = c;
    it.tx_word = t;
    it.miso_level = m;
    tick_queue.push_back(it);
    queued++;
  endtask

  task automatic push_random(input cmd_t c);
    push_item(c, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  // Wait until every tick has its result, then let the pipeline settle
  task automatic wait_drained();
    while (tick_queue.size() != 0 || s_tvalid || expected_pins.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SPI_MODE:       mode_r = val[1:0];
      CFG_WORD_BITS:      bits_r = val[4:0];
      CFG_LSB_FIRST:      lsbf_r = val[0];
      CFG_CS_ACTIVE_HIGH: cshi_r = val[0];
      CFG_UNIT_TICKS:     unit_r = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] m, b, l, c, u);
    write_reg(CFG_SPI_MODE, m);
    write_reg(CFG_WORD_BITS, b);
    write_reg(CFG_LSB_FIRST, l);
    write_reg(CFG_CS_ACTIVE_HIGH, c);
    write_reg(CFG_UNIT_TICKS, u);
    settings++;
  endtask

  // Mostly complete framed words with random data, plus stray commands
  task automatic gen_phase(input int target);
    int cnt, k, nt;
    cnt = 0;
    while (cnt < target) begin
      if ($urandom_range(0, 9) < 7) begin
        push_random(CMD_OPEN);
        push_random(CMD_START);
        nt = 3 * unit_eff() * bits_eff();
        for (k = 0; k < nt; k++) begin
          if ($urandom_range(0, 15) == 0) push_random(cmd_t'($urandom_range(0, 3)));
          else push_random(CMD_TICK);
        end
        if ($urandom_range(0, 1) != 0) push_random(CMD_CLOSE);
        cnt += nt + 3;
      end else begin
        nt = $urandom_range(1, 6);
        for (k = 0; k < nt; k++) push_random(cmd_t'($urandom_range(0, 3)));
        cnt += nt;
      end
    end
    // sometimes leave a word half done so the next settings land mid-word
    if ($urandom_range(0, 2) == 0) begin
      push_random(CMD_START);
      nt = $urandom_range(1, 8);
      for (k = 0; k < nt; k++) push_random(CMD_TICK);
    end
  endtask

  initial begin
    int          k, nt, start_q;
    logic [15:0] bv, uv;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: idle tick and close
    push_item(CMD_TICK, 16'hFFFF, 1'b1);
    push_item(CMD_CLOSE, 16'h0000, 1'b0);
    wait_drained();

    // Mode 3, word size 0, unit 0, LSB first, select active high
    set_config(16'hFFFF, 16'hFFE0, 16'h0001, 16'hFFFF, 16'h0000);
    push_item(CMD_TICK, 16'hFFFF, 1'b1);
    push_item(CMD_CLOSE, 16'h0000, 1'b0);
    push_item(CMD_OPEN, 16'h0000, 1'b0);
    push_item(CMD_START, 16'hFFFF, 1'b1);
    push_item(CMD_START, 16'h0000, 1'b0);   // ignored while busy
    push_item(CMD_OPEN, 16'h0000, 1'b1);    // select only, clock not parked
    push_item(CMD_TICK, 16'h0000, 1'b0);
    push_item(CMD_CLOSE, 16'h0000, 1'b0);
    push_item(CMD_START, 16'h0001, 1'b0);   // shifts with select released
    push_item(CMD_CLOSE, 16'hFFFF, 1'b1);
    push_item(CMD_TICK, 16'h0000, 1'b1);
    push_item(CMD_TICK, 16'h0000, 1'b0);
    wait_drained();

    // Mode 0: clock returns low on the completing tick
    set_config(16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0001);
    push_item(CMD_OPEN, 16'h0000, 1'b0);
    push_item(CMD_START, 16'h0000, 1'b1);
    for (k = 0; k < 3; k++) push_item(CMD_TICK, 16'hFFFF, 1'b1);
    push_item(CMD_CLOSE, 16'h0000, 1'b0);
    wait_drained();

    // Long unit, one-bit word, no idling
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    set_config(16'h0001, 16'h0001, 16'h0000, 16'h0001, 16'h0040);
    push_random(CMD_OPEN);
    push_random(CMD_START);
    nt = 3 * unit_eff() * bits_eff();
    for (k = 0; k < nt; k++) push_random(CMD_TICK);
    push_random(CMD_CLOSE);
    wait_drained();

    // Random settings and traffic
    start_q = queued;
    while (queued - start_q < RANDOM_TICKS) begin
      src_idle_on = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       bv = 16'd0;
        1:       bv = 16'($urandom_range(17, 31));
        2:       bv = 16'd16;
        3:       bv = 16'd1;
        default: bv = 16'($urandom_range(2, 12));
      endcase
      bv = 16'(($urandom_range(0, 2047) << 5) | 32'(bv));
      case ($urandom_range(0, 7))
        0:       uv = 16'd0;
        1:       uv = 16'($urandom_range(4, 20));
        default: uv = 16'($urandom_range(1, 3));
      endcase
      set_config(16'($urandom_range(0, 65535)), bv, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), uv);
      gen_phase(120);
      wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Ran %0d ticks under %0d register settings, %0d words completed.",
             ticks_sent, settings, words_done);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
